// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the sequence window loss monitor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("assertion failed: condition does not hold");

// Checks that a trigger implies a condition at the same clock edge.
`define ASSERT_IMPLY(lbl, ck, rn, trig, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |-> (cond)) \
        else $error("assertion failed: implication does not hold");

`endif

// ----- rtl/swlm_pkg.sv -----
// Shared constants for the sequence window loss monitor.
package swlm_pkg;

    localparam int WINDOW_DEFAULT = 256;
    localparam int SEQ_W          = 64;
    localparam int THRESH_W       = 17;
    localparam int FRAC_BITS      = 16;
    localparam int EXP_OUT_W      = 9;
    localparam int RCV_OUT_W      = 9;
    localparam int LOST_OUT_W     = 8;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd6554;

endpackage

// ----- rtl/swlm_ring_mem.sv -----
// Ring memory of accepted sequence numbers with one write and one registered read port.
module swlm_ring_mem #(
    parameter int WINDOW = swlm_pkg::WINDOW_DEFAULT,
    parameter int IDX_W  = $clog2(WINDOW)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [IDX_W-1:0]           wr_addr,
    input  logic [swlm_pkg::SEQ_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [IDX_W-1:0]           rd_addr,
    output logic [swlm_pkg::SEQ_W-1:0] rd_data
);

    logic [swlm_pkg::SEQ_W-1:0] mem [WINDOW];
    logic [swlm_pkg::SEQ_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/swlm_loss_calc.sv -----
// Lost count and threshold compare stage for the loss warning.
`include "assert_macros.svh"

module swlm_loss_calc #(
    parameter int CNT_W = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [CNT_W-1:0]              expected,
    input  logic [CNT_W-1:0]              received,
    input  logic [swlm_pkg::THRESH_W-1:0] threshold,
    output logic [CNT_W-1:0]              lost,
    output logic                          warn
);

    localparam int PROD_W = swlm_pkg::THRESH_W + CNT_W;

    logic [CNT_W-1:0]  lost_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              done_reg;
    logic [PROD_W-1:0] lhs;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lost_reg <= expected - received;
            prod_reg <= PROD_W'(threshold) * PROD_W'(expected);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    assign lhs  = {1'b0, lost_reg, {swlm_pkg::FRAC_BITS{1'b0}}};
    assign lost = lost_reg;
    assign warn = lhs > prod_reg;

    // With nothing lost the loss fraction cannot exceed any threshold.
    `ASSERT_IMPLY(a_no_loss_no_warn, clk, rst_n, done_reg && (lost_reg == '0), !warn)

endmodule

// ----- rtl/sequence_window_loss_monitor_core.sv -----
// Top level of the sequence window loss monitor: control sequencer and result register.
// An accepted sequence number passes the decide, drop-read, write, calc and done states
// from input beat to a loaded result, with a further drop-read and drop-compare pass for
// each ring entry that falls out of the window, since stale entries are checked one at a
// time through the single registered read port of the ring memory; a rejected number goes
// from decide straight to done. The next beat is taken in the cycle after the result is
// loaded, and a result waits in the output register while the following item is processed.
`include "assert_macros.svh"

module sequence_window_loss_monitor_core #(
    parameter int WINDOW = swlm_pkg::WINDOW_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [swlm_pkg::SEQ_W-1:0]         seq_number,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               accepted,
    output logic                               window_cleared,
    output logic                               loss_warning,
    output logic [swlm_pkg::EXP_OUT_W-1:0]     expected_count,
    output logic [swlm_pkg::RCV_OUT_W-1:0]     received_count,
    output logic [swlm_pkg::LOST_OUT_W-1:0]    lost_count,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [swlm_pkg::THRESH_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int EXT_W = CNT_W + swlm_pkg::EXP_OUT_W;

    localparam logic [swlm_pkg::SEQ_W-1:0] WIN_SEQ = swlm_pkg::SEQ_W'(WINDOW);
    localparam logic [SUM_W-1:0]           WIN_SUM = SUM_W'(WINDOW);
    localparam logic [IDX_W-1:0]           IDX_LAST = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]           WIN_CNT = CNT_W'(WINDOW);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECIDE   = 3'd1;
    localparam logic [2:0] S_DROP_RD  = 3'd2;
    localparam logic [2:0] S_DROP_CMP = 3'd3;
    localparam logic [2:0] S_WRITE    = 3'd4;
    localparam logic [2:0] S_CALC     = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic [swlm_pkg::SEQ_W-1:0]    seq_reg, seq_next;
    logic [swlm_pkg::SEQ_W-1:0]    newest_reg, newest_next;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic [CNT_W-1:0]              occ_reg, occ_next;
    logic [CNT_W-1:0]              exp_reg, exp_next;
    logic                          acc_reg, acc_next;
    logic                          clr_reg, clr_next;
    logic [swlm_pkg::THRESH_W-1:0] thr_reg;

    logic                          out_valid_reg;
    logic                          o_acc_reg;
    logic                          o_clr_reg;
    logic                          o_warn_reg;
    logic [swlm_pkg::EXP_OUT_W-1:0]  o_exp_reg;
    logic [swlm_pkg::RCV_OUT_W-1:0]  o_rcv_reg;
    logic [swlm_pkg::LOST_OUT_W-1:0] o_lost_reg;

    logic                          mem_wr_en;
    logic [IDX_W-1:0]              mem_wr_addr;
    logic                          mem_rd_en;
    logic [swlm_pkg::SEQ_W-1:0]    mem_rd_data;
    logic [SUM_W-1:0]              tail_sum;
    logic [swlm_pkg::SEQ_W-1:0]    age;
    logic                          far_behind;
    logic                          not_newer;
    logic                          calc_start;
    logic [CNT_W-1:0]              calc_lost;
    logic                          calc_warn;
    logic                          out_free;
    logic                          load_out;
    logic [EXT_W-1:0]              exp_ext;
    logic [EXT_W-1:0]              rcv_ext;
    logic [EXT_W-1:0]              lost_ext;

    swlm_ring_mem #(
        .WINDOW (WINDOW),
        .IDX_W  (IDX_W)
    ) u_ring_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (seq_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (head_reg),
        .rd_data (mem_rd_data)
    );

    swlm_loss_calc #(
        .CNT_W (CNT_W)
    ) u_loss_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (calc_start),
        .expected  (exp_reg),
        .received  (occ_reg),
        .threshold (thr_reg),
        .lost      (calc_lost),
        .warn      (calc_warn)
    );

    assign tail_sum    = SUM_W'(head_reg) + SUM_W'(occ_reg);
    assign mem_wr_addr = (tail_sum >= WIN_SUM) ? IDX_W'(tail_sum - WIN_SUM)
                                               : tail_sum[IDX_W-1:0];
    assign age         = seq_reg - mem_rd_data;
    assign far_behind  = (newest_reg >= WIN_SEQ) && (seq_reg <= newest_reg - WIN_SEQ);
    assign not_newer   = seq_reg <= newest_reg;
    assign out_free    = !out_valid_reg || out_ready;

    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign mem_wr_en  = (state_reg == S_WRITE);
    assign mem_rd_en  = (state_reg == S_DROP_RD) && (occ_reg != '0);
    assign calc_start = (state_reg == S_CALC);
    assign load_out   = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        state_next  = state_reg;
        seq_next    = seq_reg;
        newest_next = newest_reg;
        head_next   = head_reg;
        occ_next    = occ_reg;
        exp_next    = exp_reg;
        acc_next    = acc_reg;
        clr_next    = clr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    seq_next   = seq_number;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                acc_next   = 1'b1;
                clr_next   = 1'b0;
                state_next = S_DROP_RD;
                if (occ_reg != '0)
                begin
                    if (far_behind)
                    begin
                        head_next = '0;
                        occ_next  = '0;
                        clr_next  = 1'b1;
                    end
                    else if (not_newer)
                    begin
                        acc_next   = 1'b0;
                        state_next = S_DONE;
                    end
                end
            end
            S_DROP_RD:
            begin
                state_next = (occ_reg != '0) ? S_DROP_CMP : S_WRITE;
            end
            S_DROP_CMP:
            begin
                if (age >= WIN_SEQ)
                begin
                    head_next  = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
                    occ_next   = occ_reg - 1'b1;
                    state_next = S_DROP_RD;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                occ_next    = occ_reg + 1'b1;
                newest_next = seq_reg;
                exp_next    = (seq_reg >= WIN_SEQ - 1'b1) ? WIN_CNT
                                                          : seq_reg[CNT_W-1:0] + 1'b1;
                state_next  = S_CALC;
            end
            S_CALC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            newest_reg <= '0;
            head_reg   <= '0;
            occ_reg    <= '0;
            thr_reg    <= swlm_pkg::THRESH_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            head_reg   <= head_next;
            occ_reg    <= occ_next;
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
        exp_reg <= exp_next;
        acc_reg <= acc_next;
        clr_reg <= clr_next;
    end

    // Counts are reported masked to the port widths.
    assign exp_ext  = EXT_W'(exp_reg);
    assign rcv_ext  = EXT_W'(occ_reg);
    assign lost_ext = EXT_W'(calc_lost);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_acc_reg  <= acc_reg;
            o_clr_reg  <= acc_reg && clr_reg;
            o_warn_reg <= acc_reg && calc_warn;
            o_exp_reg  <= acc_reg ? exp_ext[swlm_pkg::EXP_OUT_W-1:0] : '0;
            o_rcv_reg  <= rcv_ext[swlm_pkg::RCV_OUT_W-1:0];
            o_lost_reg <= acc_reg ? lost_ext[swlm_pkg::LOST_OUT_W-1:0] : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = o_acc_reg;
    assign window_cleared = o_clr_reg;
    assign loss_warning   = o_warn_reg;
    assign expected_count = o_exp_reg;
    assign received_count = o_rcv_reg;
    assign lost_count     = o_lost_reg;

    // The ring never holds more entries than the window.
    `ASSERT_ALWAYS(a_occ_bound, clk, rst_n, occ_reg <= WIN_CNT)
    // The oldest entry pointer stays inside the ring.
    `ASSERT_ALWAYS(a_head_bound, clk, rst_n, head_reg <= IDX_LAST)
    // An accepted number always leaves at least one entry and no more than expected.
    `ASSERT_IMPLY(a_done_counts, clk, rst_n, (state_reg == S_DONE) && acc_reg, (occ_reg != '0) && (occ_reg <= exp_reg))

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sequence window loss monitor core.
module tb_top;

    localparam int WIN = swlm_pkg::WINDOW_DEFAULT;

    typedef struct packed {
        logic                              accepted;
        logic                              window_cleared;
        logic                              loss_warning;
        logic [swlm_pkg::EXP_OUT_W-1:0]    expected_count;
        logic [swlm_pkg::RCV_OUT_W-1:0]    received_count;
        logic [swlm_pkg::LOST_OUT_W-1:0]   lost_count;
    } loss_report_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [swlm_pkg::SEQ_W-1:0]        seq_number = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic                              accepted;
    logic                              window_cleared;
    logic                              loss_warning;
    logic [swlm_pkg::EXP_OUT_W-1:0]    expected_count;
    logic [swlm_pkg::RCV_OUT_W-1:0]    received_count;
    logic [swlm_pkg::LOST_OUT_W-1:0]   lost_count;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [swlm_pkg::THRESH_W-1:0]     cfg_data = '0;

    logic [63:0]                       pending_seqs [$];
    loss_report_t                      expected_reports [$];
    int                                items_offered = 0;
    int                                reports_seen = 0;
    int                                mismatch_count = 0;

    logic [63:0]                       held_seqs [WIN];
    int unsigned                       oldest_slot = 0;
    int unsigned                       held_count = 0;
    logic [63:0]                       newest_held = '0;
    logic [swlm_pkg::THRESH_W-1:0]     warn_threshold = swlm_pkg::THRESH_RESET;

    int                                burst_left = 0;
    int                                gap_left = 0;
    int                                sink_mode = 0;
    int                                sink_mode_left = 0;
    int                                hold_left = 0;
    int                                beats_taken = 0;
    int                                sink_cycle = 0;

    logic [63:0] directed_seqs [$] = '{
        64'd0, 64'd0, 64'd1, 64'd3, 64'd2, 64'd3, 64'd10, 64'd254, 64'd255, 64'd256,
        64'd300, 64'd700, 64'd445, 64'd444, 64'd445,
        64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF80,
        64'd5, 64'd0, 64'd6
    };

    sequence_window_loss_monitor_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .seq_number     (seq_number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accepted       (accepted),
        .window_cleared (window_cleared),
        .loss_warning   (loss_warning),
        .expected_count (expected_count),
        .received_count (received_count),
        .lost_count     (lost_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic loss_report_t predict_report(input logic [63:0] seq);
        loss_report_t r;
        logic [63:0]  want_cnt;
        logic [63:0]  miss_cnt;
        logic [63:0]  lhs;
        logic [63:0]  rhs;
        logic         cleared;
        r = '0;
        cleared = 1'b0;
        if (held_count > 0)
        begin
            if (newest_held >= 64'(WIN) && seq <= newest_held - 64'(WIN))
            begin
                oldest_slot = 0;
                held_count = 0;
                cleared = 1'b1;
            end
            else if (seq <= newest_held)
            begin
                r.received_count = 9'(held_count);
                return r;
            end
        end
        while (held_count > 0 && seq - held_seqs[oldest_slot] >= 64'(WIN))
        begin
            oldest_slot = (oldest_slot + 1) % WIN;
            held_count--;
        end
        held_seqs[(oldest_slot + held_count) % WIN] = seq;
        held_count++;
        newest_held = seq;
        want_cnt = (seq >= 64'(WIN - 1)) ? 64'(WIN) : seq + 64'd1;
        miss_cnt = want_cnt - 64'(held_count);
        lhs = miss_cnt << swlm_pkg::FRAC_BITS;
        rhs = 64'(warn_threshold) * want_cnt;
        r.accepted = 1'b1;
        r.window_cleared = cleared;
        r.loss_warning = (lhs > rhs);
        r.expected_count = want_cnt[8:0];
        r.received_count = 9'(held_count);
        r.lost_count = miss_cnt[7:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : seq_driver
        logic free;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            seq_number <= '0;
        end
        else
        begin
            free = !in_valid || in_ready;
            if (in_valid && in_ready)
                expected_reports.push_back(predict_report(seq_number));
            if (free)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_seqs.size() > 0)
                begin
                    in_valid <= 1'b1;
                    seq_number <= pending_seqs.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // The sink switches between stall patterns and holds off twice for a long stretch
    // so that the core backs up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            sink_cycle++;
            if (out_valid && out_ready)
            begin
                beats_taken++;
                if (beats_taken == 100 || beats_taken == 600)
                    hold_left = 400;
            end
            if (sink_mode_left == 0)
            begin
                sink_mode = $urandom_range(0, 3);
                sink_mode_left = $urandom_range(20, 200);
            end
            else
                sink_mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (sink_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (sink_cycle % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : report_monitor
        loss_report_t seen;
        loss_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {accepted, window_cleared, loss_warning,
                    expected_count, received_count, lost_count};
            reports_seen++;
            if (expected_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result beat with nothing expected: acc=%0d clr=%0d warn=%0d exp=%0d rcv=%0d lost=%0d",
                             seen.accepted, seen.window_cleared, seen.loss_warning,
                             seen.expected_count, seen.received_count, seen.lost_count);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected acc=%0d clr=%0d warn=%0d exp=%0d rcv=%0d lost=%0d, got acc=%0d clr=%0d warn=%0d exp=%0d rcv=%0d lost=%0d",
                                 want.accepted, want.window_cleared, want.loss_warning,
                                 want.expected_count, want.received_count, want.lost_count,
                                 seen.accepted, seen.window_cleared, seen.loss_warning,
                                 seen.expected_count, seen.received_count, seen.lost_count);
                end
            end
        end
    end

    task automatic queue_seq(input logic [63:0] seq);
        pending_seqs.push_back(seq);
        items_offered++;
    endtask

    task automatic wait_drained();
        while (reports_seen != items_offered)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [swlm_pkg::THRESH_W-1:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        warn_threshold = value;
    endtask

    // Mostly in-order streams with losses, duplicates, jumps, sender restarts and noise.
    task automatic load_stream(input int count, input bit clean);
        logic [63:0] cursor;
        int          pick;
        int          k;
        case ($urandom_range(0, 2))
            0:       cursor = 64'($urandom_range(0, 20));
            1:       cursor = {$urandom, $urandom};
            default: cursor = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 600));
        endcase
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (clean)
                pick = (pick < 95) ? 0 : 75;
            if (pick < 60)
            begin
                cursor += 64'd1;
                queue_seq(cursor);
            end
            else if (pick < 72)
            begin
                cursor += 64'($urandom_range(2, 8));
                queue_seq(cursor);
            end
            else if (pick < 80)
                queue_seq(cursor - ((cursor < 64'd6) ? 64'd0 : 64'($urandom_range(0, 6))));
            else if (pick < 86)
            begin
                cursor += 64'($urandom_range(100, 400));
                queue_seq(cursor);
            end
            else if (pick < 92)
            begin
                cursor = 64'($urandom_range(0, 40));
                queue_seq(cursor);
            end
            else if (pick < 96)
            begin
                cursor = {$urandom, $urandom};
                queue_seq(cursor);
            end
            else
                queue_seq({$urandom, $urandom});
        end
    endtask

    task automatic run_phase(input logic [swlm_pkg::THRESH_W-1:0] threshold, input int count,
                             input bit clean);
        write_threshold(threshold);
        load_stream(count, clean);
        wait_drained();
    endtask

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_seqs[i])
            queue_seq(directed_seqs[i]);
        wait_drained();
        run_phase(17'd0, 300, 1'b1);
        run_phase(17'd65536, 130, 1'b0);
        run_phase(17'd131071, 120, 1'b0);
        run_phase(17'($urandom_range(0, 65536)), 130, 1'b0);
        run_phase(17'd1, 120, 1'b0);
        run_phase(17'($urandom_range(0, 131071)), 130, 1'b0);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("sequence_window_loss_monitor_core test passed");
        else
            $display("sequence_window_loss_monitor_core test failed");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("sequence_window_loss_monitor_core test failed");
        $finish;
    end

endmodule
